// File: rtl/core/assert_macros.svh
// Assertion macros, included by the cipher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: rtl/core/aescbc_pkg.sv
// Package: AES-128 constants, tables and round functions.
package aescbc_pkg;

   localparam int ROUNDS    = 10;
   localparam int KEY_ROWS  = ROUNDS + 1;
   localparam int ROW_AW    = $clog2(KEY_ROWS);
   localparam int HALF_W    = 64;
   localparam int BLK_W     = 128;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [BLK_W-1:0]  blk_type;
   typedef logic [7:0]        byte_type;

   localparam byte_type SBOX_FWD [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam byte_type SBOX_INV [0:255] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam byte_type RCON_FIRST = 8'h01;
   localparam byte_type GF_POLY    = 8'h1b;

   function automatic byte_type xt(input byte_type v);
      xt = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // SubBytes with ShiftRows, forward or inverse.
   function automatic blk_type sub_shift(input blk_type s, input logic inv);
      blk_type t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
            t[BLK_W-1-8*(c*4+r) -: 8] = inv ? SBOX_INV[s[BLK_W-1-8*(src*4+r) -: 8]]
                                            : SBOX_FWD[s[BLK_W-1-8*(src*4+r) -: 8]];
         end
      end
      sub_shift = t;
   endfunction

   // MixColumns, forward or inverse, on all four columns.
   function automatic blk_type mix(input blk_type s, input logic inv);
      blk_type  t;
      byte_type a [4];
      byte_type m1 [4];
      byte_type m2 [4];
      byte_type m3 [4];
      byte_type p  [4];
      byte_type acc;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j]  = s[BLK_W-1-8*(c*4+j) -: 8];
            m1[j] = xt(a[j]);
            m2[j] = xt(m1[j]);
            m3[j] = xt(m2[j]);
         end
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
               // coefficient position relative to the output row
               unique case ((j - r + 4) & 3)
                  0: p[j] = inv ? (m3[j] ^ m2[j] ^ m1[j]) : m1[j];
                  1: p[j] = inv ? (m3[j] ^ m1[j] ^ a[j]) : (m1[j] ^ a[j]);
                  2: p[j] = inv ? (m3[j] ^ m2[j] ^ a[j]) : a[j];
                  default: p[j] = inv ? (m3[j] ^ a[j]) : a[j];
               endcase
               acc = acc ^ p[j];
            end
            t[BLK_W-1-8*(c*4+r) -: 8] = acc;
         end
      end
      mix = t;
   endfunction

   // Next round key from the previous one.
   function automatic blk_type next_key(input blk_type k, input byte_type rc);
      logic [31:0] w0, w1, w2, w3, tw;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      tw = {SBOX_FWD[w3[23:16]] ^ rc, SBOX_FWD[w3[15:8]],
            SBOX_FWD[w3[7:0]], SBOX_FWD[w3[31:24]]};
      w0 = w0 ^ tw;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

endpackage

// File: rtl/core/aescbc_if.sv
// Request and response channel interfaces.
interface aescbc_req_if;
   import aescbc_pkg::*;
   logic     valid;
   logic     ready;
   half_type block_high;
   half_type block_low;
   logic     new_message;
   modport source (output valid, output block_high, output block_low,
                   output new_message, input ready);
   modport sink   (input valid, input block_high, input block_low,
                   input new_message, output ready);
endinterface

interface aescbc_rsp_if;
   import aescbc_pkg::*;
   logic     valid;
   logic     ready;
   half_type result_high;
   half_type result_low;
   modport source (output valid, output result_high, output result_low, input ready);
   modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

// File: rtl/core/aescbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aescbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: rtl/core/aes128_cbc_cipher_top.sv
// Top level: AES-128 CBC cipher with iterative round unit and APB register port.
//
//  channel   direction  handshake           payload
//  req       in         valid/ready         block_high, block_low, new_message
//  rsp       out        valid/ready         result_high, result_low
//  apb       in         psel/penable/pready key, iv and decrypt registers
//
// An accepted request passes through the LOAD, INIT, ROUND and FINISH states to a
// loaded response register; with new_message set it first expands the key (one round key a cycle).
// The single round unit (S-box layer, MixColumns, key add) runs once per cycle, and
// the round-key RAM port sets one key row per cycle.
// Reset is synchronous; it clears control state, the registers and the chain.
// The response register frees the round unit; a stalled response holds only the
// final write-back, and req.ready stays low while a request is in flight.
module aes128_cbc_cipher_top (
   input  logic                       clock,
   input  logic                       reset,
   aescbc_req_if.sink                 req,
   aescbc_rsp_if.source               rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [5:0]                 paddr,
   input  aescbc_pkg::half_type       pwdata,
   output aescbc_pkg::half_type       prdata,
   output logic                       pready
);
   import aescbc_pkg::*;

   // register indexes
   localparam logic [2:0] REG_KEY_HI = 3'd0;
   localparam logic [2:0] REG_KEY_LO = 3'd1;
   localparam logic [2:0] REG_IV_HI  = 3'd2;
   localparam logic [2:0] REG_IV_LO  = 3'd3;
   localparam logic [2:0] REG_DECR   = 3'd4;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_INIT   = 3'd3;
   localparam logic [2:0] ST_ROUND  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROUNDS);

   half_type key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic     decr_ff;

   logic [2:0]        state_ff, state_in;
   logic [ROW_AW-1:0] round_ff, round_in;
   byte_type          rcon_ff, rcon_in;
   blk_type           rkey_ff, rkey_in;
   blk_type           cs_ff, cs_in;
   blk_type           chain_ff, chain_in;
   blk_type           blk_ff, blk_in;
   blk_type           out_ff, out_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept, wr_en, cfg_wr, last_round, out_free;
   logic [2:0]        cfg_idx;
   logic [ROW_AW-1:0] wr_addr, rd_addr;
   blk_type           wr_data, rd_key, expanded, round_val;

   assign pready   = 1'b1;
   assign cfg_wr   = psel & penable & pwrite;
   assign cfg_idx  = paddr[5:3];
   assign req.ready = (state_ff == ST_IDLE);
   assign accept   = req.valid & req.ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_high = out_ff[127:64];
   assign rsp.result_low  = out_ff[63:0];
   assign last_round = (round_ff == LAST_ROW);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // register read-back
   always_comb begin
      unique case (cfg_idx)
         REG_KEY_HI: prdata = key_hi_ff;
         REG_KEY_LO: prdata = key_lo_ff;
         REG_IV_HI:  prdata = iv_hi_ff;
         REG_IV_LO:  prdata = iv_lo_ff;
         REG_DECR:   prdata = {{(HALF_W-1){1'b0}}, decr_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         iv_hi_ff  <= '0;
         iv_lo_ff  <= '0;
         decr_ff   <= 1'b0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_KEY_HI: key_hi_ff <= pwdata;
            REG_KEY_LO: key_lo_ff <= pwdata;
            REG_IV_HI:  iv_hi_ff  <= pwdata;
            REG_IV_LO:  iv_lo_ff  <= pwdata;
            REG_DECR:   decr_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Round keys live in an 11-row RAM, one 128-bit round key per row.
   assign expanded = next_key(rkey_ff, rcon_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = expanded;
      if (accept && req.new_message) begin
         // row 0 is the cipher key itself
         wr_en   = 1'b1;
         wr_data = {key_hi_ff, key_lo_ff};
      end else if (state_ff == ST_EXPAND) begin
         wr_en   = 1'b1;
         wr_addr = round_ff;
      end
   end

   // Present the row needed in the next cycle; read data is registered.
   always_comb begin
      unique case (state_ff)
         ST_LOAD:  rd_addr = decr_ff ? LAST_ROW : '0;
         ST_INIT:  rd_addr = decr_ff ? LAST_ROW - 1'b1 : ROW_AW'(1);
         ST_ROUND: begin
            if (last_round) begin
               rd_addr = '0;
            end else begin
               rd_addr = decr_ff ? LAST_ROW - round_ff - 1'b1 : round_ff + 1'b1;
            end
         end
         default:  rd_addr = '0;
      endcase
   end

   aescbc_ram #(.WIDTH(BLK_W), .DEPTH(KEY_ROWS)) u_key_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rd_key)
   );

   // The shared round unit: forward is sub/shift, mix, add key;
   // inverse is sub/shift, add key, mix. The last round skips the mix.
   always_comb begin
      blk_type ss;
      ss = sub_shift(cs_ff, decr_ff);
      if (decr_ff) begin
         round_val = last_round ? (ss ^ rd_key) : mix(ss ^ rd_key, 1'b1);
      end else begin
         round_val = (last_round ? ss : mix(ss, 1'b0)) ^ rd_key;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      rcon_in      = rcon_ff;
      rkey_in      = rkey_ff;
      cs_in        = cs_ff;
      chain_in     = chain_ff;
      blk_in       = blk_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               blk_in = {req.block_high, req.block_low};
               if (req.new_message) begin
                  // restart the chain and expand a fresh key schedule
                  chain_in = {iv_hi_ff, iv_lo_ff};
                  rkey_in  = {key_hi_ff, key_lo_ff};
                  rcon_in  = RCON_FIRST;
                  round_in = ROW_AW'(1);
                  state_in = ST_EXPAND;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EXPAND: begin
            rkey_in = expanded;
            rcon_in = xt(rcon_ff);
            if (last_round) begin
               state_in = ST_LOAD;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_LOAD: state_in = ST_INIT;
         ST_INIT: begin
            cs_in    = (decr_ff ? blk_ff : (blk_ff ^ chain_ff)) ^ rd_key;
            round_in = ROW_AW'(1);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cs_in = round_val;
            if (last_round) begin
               state_in = ST_FINISH;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (out_free) begin
               out_in       = decr_ff ? (cs_ff ^ chain_ff) : cs_ff;
               chain_in     = decr_ff ? blk_ff : cs_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rcon_ff      <= RCON_FIRST;
         cs_ff        <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rcon_ff      <= rcon_in;
         cs_ff        <= cs_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rkey_ff <= rkey_in;
      blk_ff  <= blk_in;
      out_ff  <= out_in;
   end

`include "assert_macros.svh"

   `ASSERT_PROP(a_new_msg_expands, clock, reset, (accept && req.new_message) |=> (state_ff == ST_EXPAND))
   `ASSERT_PROP(a_last_round_ends, clock, reset, (state_ff == ST_ROUND && last_round) |=> (state_ff == ST_FINISH))
   `ASSERT_NEVER(a_rd_in_range, clock, reset, rd_addr > LAST_ROW)
   `ASSERT_NEVER(a_wr_row_zero_busy, clock, reset, wr_en && (wr_addr == '0) && (state_ff != ST_IDLE))
   `ASSERT_PROP(a_finish_loads_rsp, clock, reset, (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)

endmodule

// File: bench/aescbc_tb_pkg.sv
// Register map of the cipher's configuration port, shared by the bench files.
package aescbc_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      REG_KEY_HIGH = 0,
      REG_KEY_LOW  = 1,
      REG_IV_HIGH  = 2,
      REG_IV_LOW   = 3,
      REG_DECRYPT  = 4,
      REG_UNMAPPED = 5
   } reg_index_e;

   localparam int REG_STRIDE = 8;
endpackage

// File: bench/aescbc_checker.sv
// Checker: watches the request, response and register traffic and compares results.
module aescbc_checker
   import aescbc_pkg::*;
   import aescbc_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   aescbc_req_if       req,
   aescbc_rsp_if       rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [5:0]  csr_paddr,
   input  half_type    csr_pwdata,
   output int          mismatches,
   output int          outstanding,
   output int          blocks_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   half_type    key_hi, key_lo, iv_hi, iv_lo;
   logic        decrypt_mode;
   blk_type     chain;
   logic [31:0] round_keys [44];
   blk_type     expected_blocks [$];

   function automatic byte_type gmul(input byte_type a, input byte_type b);
      byte_type p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic blk_type add_round_key(input blk_type s, input int r);
      for (int c = 0; c < 4; c++)
         s[127-32*c -: 32] = s[127-32*c -: 32] ^ round_keys[r*4+c];
      return s;
   endfunction

   function automatic blk_type substitute_rows(input blk_type s, input logic inv);
      blk_type t;
      int      src;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
            t[127-8*(c*4+r) -: 8] = inv ? SBOX_INV[s[127-8*(src*4+r) -: 8]]
                                        : SBOX_FWD[s[127-8*(src*4+r) -: 8]];
         end
      return t;
   endfunction

   function automatic blk_type mix_columns(input blk_type s, input logic inv);
      blk_type  t;
      byte_type coef [4];
      byte_type acc;
      if (inv) begin
         coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      end else begin
         coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      end
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int j = 0; j < 4; j++)
               acc = acc ^ gmul(coef[(j - r + 4) & 3], s[127-8*(c*4+j) -: 8]);
            t[127-8*(c*4+r) -: 8] = acc;
         end
      return t;
   endfunction

   task automatic expand_round_keys();
      logic [31:0] w;
      byte_type    rc;
      rc = 8'h01;
      round_keys[0] = key_hi[63:32];
      round_keys[1] = key_hi[31:0];
      round_keys[2] = key_lo[63:32];
      round_keys[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
         w = round_keys[i-1];
         if ((i & 3) == 0) begin
            w = {w[23:0], w[31:24]};
            w = {SBOX_FWD[w[31:24]] ^ rc, SBOX_FWD[w[23:16]],
                 SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end
         round_keys[i] = round_keys[i-4] ^ w;
      end
   endtask

   // Append one expected block at the tail of the queue.
   task automatic queue_expected(input blk_type b);
      expected_blocks = {expected_blocks, b};
   endtask

   // Work out the block that the cipher returns for one request, and advance the chain.
   task automatic predict_block(input blk_type data, input logic restart);
      blk_type s;
      if (restart) begin
         chain = {iv_hi, iv_lo};
         expand_round_keys();
      end
      if (!decrypt_mode) begin
         s = add_round_key(data ^ chain, 0);
         for (int r = 1; r <= 10; r++) begin
            s = substitute_rows(s, 1'b0);
            if (r < 10) s = mix_columns(s, 1'b0);
            s = add_round_key(s, r);
         end
         chain = s;
         queue_expected(s);
      end else begin
         s = add_round_key(data, 10);
         for (int r = 9; r >= 0; r--) begin
            s = substitute_rows(s, 1'b1);
            s = add_round_key(s, r);
            if (r > 0) s = mix_columns(s, 1'b1);
         end
         queue_expected(s ^ chain);
         chain = data;
      end
   endtask

   task automatic report_mismatch(input string what, input half_type got, input half_type want);
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      blocks_checked = 0;
      outstanding = 0;
      foreach (round_keys[i]) round_keys[i] = '0;
   end

   always @(posedge clock) begin
      blk_type want;
      if (reset) begin
         key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
         decrypt_mode = 1'b0;
         chain = '0;
         expected_blocks.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (int'(csr_paddr) / REG_STRIDE)
               REG_KEY_HIGH: key_hi = csr_pwdata;
               REG_KEY_LOW:  key_lo = csr_pwdata;
               REG_IV_HIGH:  iv_hi = csr_pwdata;
               REG_IV_LOW:   iv_lo = csr_pwdata;
               REG_DECRYPT:  decrypt_mode = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            predict_block({req.block_high, req.block_low}, req.new_message);
         if (rsp.valid && rsp.ready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected result_high", rsp.result_high, '0);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp.result_high !== want[127:64])
                  report_mismatch("result_high", rsp.result_high, want[127:64]);
               if (rsp.result_low !== want[63:0])
                  report_mismatch("result_low", rsp.result_low, want[63:0]);
               blocks_checked++;
            end
         end
      end
      outstanding = expected_blocks.size();
   end
endmodule

// File: bench/tb.sv
// Testbench top: drives requests and register writes into the CBC cipher and gives the verdict.
module tb;
   import aescbc_pkg::*;
   import aescbc_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES  = 40;    // idle time before the registers are touched again
   localparam int HOLD_OFF       = 300;   // long receiver stall for back-pressure

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_psel = 1'b0;
   logic       csr_penable = 1'b0;
   logic       csr_pwrite = 1'b0;
   logic [5:0] csr_paddr = '0;
   half_type   csr_pwdata = '0;
   half_type   csr_prdata;
   logic       csr_pready;

   aescbc_req_if req ();
   aescbc_rsp_if rsp ();

   int mismatches, outstanding, blocks_checked;
   int requests_sent = 0;
   int messages_sent = 0;
   int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
   int recv_idle_pct = 0;   // chance in a hundred that the receiver stalls a cycle
   logic hold_wanted = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   aes128_cbc_cipher_top dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req.sink),
      .rsp     (rsp.source),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   aescbc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .blocks_checked (blocks_checked)
   );

   initial begin
      req.valid = 1'b0;
      req.block_high = '0;
      req.block_low = '0;
      req.new_message = 1'b0;
      rsp.ready = 1'b0;
   end

   // Receiver: stall at random, or hold off for a long stretch once when asked.
   always @(negedge clock) begin
      if (hold_wanted && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request, idling first by chance; return at the falling edge after acceptance.
   task automatic send_request(input half_type hi, input half_type lo, input logic restart);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid = 1'b1;
      req.block_high = hi;
      req.block_low = lo;
      req.new_message = restart;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      requests_sent++;
      if (restart) messages_sent++;
   endtask

   // Setup then access phase; the register takes the value at the access edge.
   task automatic write_reg(input reg_index_e idx, input half_type value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = 6'(int'(idx) * REG_STRIDE);
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Drop valid, wait for every result, then let the pipe settle before touching registers.
   task automatic drain();
      req.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic half_type pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Send a message of the given length; the first block restarts the chain unless told not to.
   task automatic send_message(input int blocks, input logic restart);
      for (int b = 0; b < blocks; b++)
         send_request(pick_word(), pick_word(), restart && b == 0);
   endtask

   initial begin
      int sent_in_round;
      int len;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: the standard example key and plaintext with a zero IV first.
      write_reg(REG_KEY_HIGH, 64'h0001020304050607);
      write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
      write_reg(REG_IV_HIGH, '0);
      write_reg(REG_IV_LOW, '0);
      write_reg(REG_DECRYPT, '0);
      write_reg(REG_UNMAPPED, '1);
      send_request(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      send_request('0, '0, 1'b0);
      send_request('1, '1, 1'b0);
      send_request(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      send_request(64'h8000000000000000, 64'h0000000000000001, 1'b1);
      drain();
      // Key and IV set to all ones, encrypt then decrypt.
      write_reg(REG_KEY_HIGH, '1);
      write_reg(REG_KEY_LOW, '1);
      write_reg(REG_IV_HIGH, '1);
      write_reg(REG_IV_LOW, '1);
      send_request('0, '0, 1'b1);
      send_request('1, '1, 1'b0);
      send_request(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      drain();
      write_reg(REG_DECRYPT, 64'd1);
      send_request('0, '0, 1'b1);
      send_request('1, '1, 1'b0);
      send_request(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
      drain();
      // Key written mid-message: must not apply until the next restart.
      write_reg(REG_KEY_HIGH, '0);
      write_reg(REG_KEY_LOW, '0);
      send_request(64'h1111111111111111, 64'h2222222222222222, 1'b0);
      drain();
      // Direction flipped mid-message: continue the chain as it stands.
      write_reg(REG_DECRYPT, '0);
      send_request(64'h3333333333333333, 64'h4444444444444444, 1'b0);
      send_request('0, '1, 1'b1);
      send_request('1, '0, 1'b0);
      drain();

      // Random: three idling regimes, several register settings in each.
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 74 : 0;
         recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 16 : 0;
         for (int round = 0; round < 6; round++) begin
            write_reg(REG_KEY_HIGH, pick_word());
            write_reg(REG_KEY_LOW, pick_word());
            write_reg(REG_IV_HIGH, pick_word());
            write_reg(REG_IV_LOW, pick_word());
            write_reg(REG_DECRYPT, half_type'($urandom_range(1)));
            if (mode == 2 && round == 0) hold_wanted = 1'b1;
            sent_in_round = 0;
            while (sent_in_round < 85) begin
               len = $urandom_range(8, 1);
               // now and then carry on the previous chain across the register change
               send_message(len, !(sent_in_round == 0 && $urandom_range(3) == 0));
               sent_in_round += len;
            end
            drain();
         end
      end

      $display("covered %0d requests in %0d messages, %0d results checked",
               requests_sent, messages_sent, blocks_checked);
      $display("both directions, chain restarts and carries, key and direction changes");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/aescbc_pkg.sv
rtl/core/aescbc_if.sv
rtl/core/aescbc_ram.sv
rtl/core/aes128_cbc_cipher_top.sv
bench/aescbc_tb_pkg.sv
bench/aescbc_checker.sv
bench/tb.sv
